// File: hdl/lwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_pkg: shared types, constants and functions of the line wildcard matcher
// Holds the pattern geometry, the character codes, the register index codes
// and the position-set closure that both the configuration block and the
// matching engine use.
// ----------------------------------------------------------------------------
package lwm_pkg;

  localparam int unsigned PATTERN_MAX = 32;
  localparam int unsigned LENGTH_BITS = 16;
  localparam int unsigned SET_W       = PATTERN_MAX + 1;
  localparam int unsigned POS_W       = $clog2(SET_W);
  localparam int unsigned LINE_W      = 32;
  localparam int unsigned PLEN_W      = 6;
  localparam int unsigned WORD_COUNT  = 4;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_BYTES   = WORD_COUNT * CFG_DATA_W / 8;

  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  localparam logic [PLEN_W-1:0] PLEN_RESET = PLEN_W'(1);
  localparam logic [WORD_COUNT-1:0][CFG_DATA_W-1:0] WORDS_RESET =
      {{(WORD_COUNT-1)*CFG_DATA_W{1'b0}}, CFG_DATA_W'(42)};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4
  } cfg_reg_e;

  typedef logic [SET_W-1:0] pos_set_t;

  // Pattern in decoded form, ready for the per-byte update.
  typedef struct packed {
    logic [PATTERN_MAX-1:0][7:0] pat_bytes;
    logic [PATTERN_MAX-1:0]      star;
    logic [PATTERN_MAX-1:0]      quest;
    logic [PATTERN_MAX-1:0]      used;
    pos_set_t                    start;
    logic [POS_W-1:0]            end_pos;
  } pat_cfg_t;

  typedef struct packed {
    logic                   is_result;
    logic                   matched;
    logic [LINE_W-1:0]      line_number;
    logic [LENGTH_BITS-1:0] line_length;
  } line_res_t;

  // Star closure as a carry chain: a position that is set, or reached by a
  // carry, carries into the next position when its pattern byte is a star.
  // With A = star mask and B = set & star mask the adder carries are exactly
  // the positions reached through runs of stars.
  function automatic pos_set_t star_closure(pos_set_t set, pos_set_t star_ext);
    logic [SET_W:0] a;
    logic [SET_W:0] b;
    logic [SET_W:0] sum;
    logic [SET_W:0] carries;
    a       = {1'b0, star_ext};
    b       = {1'b0, set & star_ext};
    sum     = a + b;
    carries = sum ^ a ^ b;
    return set | carries[SET_W-1:0];
  endfunction

  function automatic pat_cfg_t derive_cfg(logic [PLEN_W-1:0] plen,
                                          logic [WORD_COUNT-1:0][CFG_DATA_W-1:0] words);
    pat_cfg_t                              res;
    logic [PLEN_W-1:0]                     n;
    logic [PATTERN_MAX*8+CFG_BYTES*8-1:0]  padded;
    logic [7:0]                            b;
    n = (plen > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : plen;
    // Bytes past the configured words read as zero.
    padded = {{(PATTERN_MAX*8){1'b0}}, words};
    for (int i = 0; i < PATTERN_MAX; i++) begin
      b                = padded[i*8 +: 8];
      res.pat_bytes[i] = b;
      res.used[i]      = (i < int'(n));
      res.star[i]      = res.used[i] && (b == CH_STAR);
      res.quest[i]     = res.used[i] && (b == CH_QUEST);
    end
    res.start   = star_closure(pos_set_t'(1), {1'b0, res.star});
    res.end_pos = POS_W'(n);
    return res;
  endfunction

endpackage

// File: hdl/lwm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_cfg: pattern configuration registers
// Holds pattern length and the four pattern words, and keeps a registered,
// decoded copy of the pattern (masks, start set, end position) for the engine.
// ----------------------------------------------------------------------------
module lwm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lwm_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lwm_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output lwm_pkg::pat_cfg_t                 pat_cfg_o
);

  logic [lwm_pkg::PLEN_W-1:0]                                   plen_q, plen_d;
  logic [lwm_pkg::WORD_COUNT-1:0][lwm_pkg::CFG_DATA_W-1:0]      words_q, words_d;
  lwm_pkg::pat_cfg_t                                            pat_cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    plen_d  = plen_q;
    words_d = words_q;
    if (cfg_valid_i) begin
      unique case (lwm_pkg::cfg_reg_e'(cfg_index_i))
        lwm_pkg::REG_PATTERN_LENGTH: plen_d     = cfg_data_i[lwm_pkg::PLEN_W-1:0];
        lwm_pkg::REG_PATTERN_WORD_0: words_d[0] = cfg_data_i;
        lwm_pkg::REG_PATTERN_WORD_1: words_d[1] = cfg_data_i;
        lwm_pkg::REG_PATTERN_WORD_2: words_d[2] = cfg_data_i;
        lwm_pkg::REG_PATTERN_WORD_3: words_d[3] = cfg_data_i;
        default: ;
      endcase
    end
  end

  // The decoded copy follows the next register values, so it is in step
  // with the registers from the cycle after the write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q    <= lwm_pkg::PLEN_RESET;
      words_q   <= lwm_pkg::WORDS_RESET;
      pat_cfg_q <= lwm_pkg::derive_cfg(lwm_pkg::PLEN_RESET, lwm_pkg::WORDS_RESET);
    end else begin
      plen_q    <= plen_d;
      words_q   <= words_d;
      pat_cfg_q <= lwm_pkg::derive_cfg(plen_d, words_d);
    end
  end

  assign pat_cfg_o = pat_cfg_q;

endmodule

// File: hdl/lwm_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwm_engine: per-byte position-set update and line bookkeeping
// Keeps the active position set, the line counter and the length of the open
// line, and forms the result for a line terminator.
// ----------------------------------------------------------------------------
module lwm_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [7:0]             byte_i,
  input  lwm_pkg::pat_cfg_t      pat_cfg_i,
  output lwm_pkg::line_res_t     res_o
);

  lwm_pkg::pos_set_t                  set_q, set_d;
  logic [lwm_pkg::LINE_W-1:0]         lines_q, lines_d;
  logic [lwm_pkg::LENGTH_BITS-1:0]    len_q, len_d;

  logic                               is_term;
  lwm_pkg::pos_set_t                  base_set;
  lwm_pkg::pos_set_t                  adv_set;
  lwm_pkg::pos_set_t                  star_ext;
  logic [lwm_pkg::PATTERN_MAX-1:0]    lit;

  assign is_term  = (byte_i == lwm_pkg::CH_CR) || (byte_i == lwm_pkg::CH_LF);
  assign star_ext = {1'b0, pat_cfg_i.star};
  // A new line starts from position zero and its star closure.
  assign base_set = (len_q == '0) ? pat_cfg_i.start : set_q;

  always_comb begin
    for (int i = 0; i < lwm_pkg::PATTERN_MAX; i++) begin
      lit[i] = pat_cfg_i.used[i] && !pat_cfg_i.star[i] &&
               (pat_cfg_i.quest[i] || (pat_cfg_i.pat_bytes[i] == byte_i));
    end
  end

  // Stars hold their position, literals and '?' move one position on.
  assign adv_set = {1'b0, base_set[lwm_pkg::PATTERN_MAX-1:0] & pat_cfg_i.star} |
                   {base_set[lwm_pkg::PATTERN_MAX-1:0] & lit, 1'b0};

  always_comb begin
    set_d   = set_q;
    lines_d = lines_q;
    len_d   = len_q;
    if (step_i) begin
      if (is_term) begin
        if (len_q != '0) begin
          lines_d = lines_q + lwm_pkg::LINE_W'(1);
          len_d   = '0;
        end
      end else begin
        set_d = lwm_pkg::star_closure(adv_set, star_ext);
        if (len_q != lwm_pkg::LEN_MAX) begin
          len_d = len_q + lwm_pkg::LENGTH_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q <= '0;
      len_q   <= '0;
    end else begin
      lines_q <= lines_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q <= set_d;
  end

  assign res_o.is_result   = is_term && (len_q != '0);
  assign res_o.matched     = set_q[pat_cfg_i.end_pos];
  assign res_o.line_number = lines_q + lwm_pkg::LINE_W'(1);
  assign res_o.line_length = len_q;

endmodule

// File: hdl/line_wildcard_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_wildcard_matcher: whole-line wildcard match over a byte stream
// Feed text one word (byte) per cycle on data_byte_i with in_valid_i; the
// block stalls the sender with in_stall_o. CR and LF end a line, runs of them
// are skipped. For each non-empty line one result word comes out on the
// output channel when its terminator is processed: matched_o, line_number_o
// and line_length_o (saturated), held while out_stall_i is high.
// The pattern ('*' any run, '?' any byte) is written through the cfg channel,
// index 0 for the length and 1 to 4 for the pattern words; the user must
// write it only while idle, which the block does not enforce. Throughput is
// one byte per cycle while in_stall_o is low, set by the position-set update
// in the engine. Bytes that end no line never wait on the output.
// When the output is stalled and a result is pending, a terminator that ends
// a line waits in the input register and in_stall_o rises.
// Reset empties both registers, clears line counter and length, and restores
// the pattern "*" with length 1.
// ----------------------------------------------------------------------------
module line_wildcard_matcher (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 matched_o,
  output logic [31:0]                          line_number_o,
  output logic [lwm_pkg::LENGTH_BITS-1:0]      line_length_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lwm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [lwm_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  lwm_pkg::pat_cfg_t   pat_cfg;
  lwm_pkg::line_res_t  res;

  logic                s1_valid_q, s1_valid_d;
  logic [7:0]          s1_byte_q;
  logic                s1_go;
  logic                s1_fire;
  logic                in_accept;
  logic                out_valid_q, out_valid_d;
  lwm_pkg::line_res_t  out_q;

  lwm_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pat_cfg_o   (pat_cfg)
  );

  lwm_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (s1_fire),
    .byte_i    (s1_byte_q),
    .pat_cfg_i (pat_cfg),
    .res_o     (res)
  );

  // The held word moves on unless it produces a result and the output
  // register is full and stalled.
  assign s1_go      = !res.is_result || !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_accept || (s1_valid_q && !s1_go);
  assign out_valid_d = (s1_fire && res.is_result) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= data_byte_i;
    end
    if (s1_fire && res.is_result) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = out_q.matched;
  assign line_number_o = out_q.line_number;
  assign line_length_o = out_q.line_length;

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && res.is_result) |=> out_valid_q)
    else $error("result of a terminated line was not loaded");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !res.is_result) |=> (out_valid_q == $past(out_valid_q && out_stall_i)))
    else $error("output valid changed on a word that ends no line");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i && res.is_result))
    else $error("input stalled without a blocked result");

  a_count_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && s1_fire && res.is_result) |=>
      (line_number_o == $past(line_number_o) + 32'd1))
    else $error("line number did not advance between back to back results");

endmodule

// File: sim/line_wildcard_matcher_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_wildcard_matcher_tb: self-checking testbench of the line wildcard matcher
// Streams text bytes into the block and loads patterns between phases. A
// position-set predictor works out each line's verdict. A checker process
// compares every result word, field by field, with the oldest prediction.
// Both sides idle at random, and one phase holds the output off for long.
// ----------------------------------------------------------------------------
module line_wildcard_matcher_tb;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned LONG_LINE     = 100;
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  typedef struct packed {
    logic                            matched;
    logic [lwm_pkg::LINE_W-1:0]      line_number;
    logic [lwm_pkg::LENGTH_BITS-1:0] line_length;
  } line_verdict_t;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  logic [7:0]                      data_byte_i = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  logic                            matched_o;
  logic [31:0]                     line_number_o;
  logic [lwm_pkg::LENGTH_BITS-1:0] line_length_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [lwm_pkg::CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [lwm_pkg::CFG_DATA_W-1:0]  cfg_data_i  = '0;

  // Predictor copy of the configuration and of the matching state.
  logic [lwm_pkg::PLEN_W-1:0] shadow_plen = lwm_pkg::PLEN_RESET;
  logic [lwm_pkg::WORD_COUNT-1:0][lwm_pkg::CFG_DATA_W-1:0] shadow_words =
      lwm_pkg::WORDS_RESET;
  lwm_pkg::pos_set_t               live_pos;
  logic [lwm_pkg::LINE_W-1:0]      lines_seen;
  logic [lwm_pkg::LENGTH_BITS-1:0] bytes_in_line;

  line_verdict_t pending_lines[$];
  int unsigned   mismatches   = 0;
  int unsigned   useful_bytes = 0;
  int unsigned   hold_cycles  = 0;
  bit            idle_sender   = 1'b1;
  bit            idle_receiver = 1'b1;

  line_wildcard_matcher u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .matched_o    (matched_o),
    .line_number_o(line_number_o),
    .line_length_o(line_length_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int used_length();
    return (shadow_plen > lwm_pkg::PLEN_W'(lwm_pkg::PATTERN_MAX)) ?
           int'(lwm_pkg::PATTERN_MAX) : int'(shadow_plen);
  endfunction

  function automatic logic [7:0] pattern_char(int i);
    logic [lwm_pkg::CFG_DATA_W-1:0] w;
    if (i >= int'(lwm_pkg::WORD_COUNT * 8)) return 8'h00;
    w = shadow_words[i / 8];
    return w[(i % 8) * 8 +: 8];
  endfunction

  function automatic lwm_pkg::pos_set_t close_over_stars(lwm_pkg::pos_set_t s);
    int n;
    n = used_length();
    for (int i = 0; i < n; i++) begin
      if (s[i] && pattern_char(i) == lwm_pkg::CH_STAR) s[i + 1] = 1'b1;
    end
    return s;
  endfunction

  function automatic lwm_pkg::pos_set_t advance_positions(lwm_pkg::pos_set_t s,
                                                          logic [7:0] c);
    lwm_pkg::pos_set_t nxt;
    int                n;
    logic [7:0]        p;
    nxt = '0;
    n   = used_length();
    for (int i = 0; i < n; i++) begin
      if (s[i]) begin
        p = pattern_char(i);
        if (p == lwm_pkg::CH_STAR) nxt[i] = 1'b1;
        else if (p == lwm_pkg::CH_QUEST || p == c) nxt[i + 1] = 1'b1;
      end
    end
    return close_over_stars(nxt);
  endfunction

  task automatic account_byte(input logic [7:0] c);
    line_verdict_t v;
    if (c == lwm_pkg::CH_CR || c == lwm_pkg::CH_LF) begin
      // A terminator with no open line is part of a skipped run.
      if (bytes_in_line != '0) begin
        lines_seen    = lines_seen + 1'b1;
        v.matched     = live_pos[used_length()];
        v.line_number = lines_seen;
        v.line_length = bytes_in_line;
        pending_lines.push_back(v);
        bytes_in_line = '0;
        live_pos      = close_over_stars(lwm_pkg::pos_set_t'(1));
        useful_bytes++;
      end
    end else begin
      // A new line starts under the pattern in force at its first byte.
      if (bytes_in_line == '0) live_pos = close_over_stars(lwm_pkg::pos_set_t'(1));
      live_pos = advance_positions(live_pos, c);
      if (bytes_in_line != lwm_pkg::LEN_MAX) bytes_in_line = bytes_in_line + 1'b1;
      useful_bytes++;
    end
  endtask

  // ------------------------------------------------------------------ drivers

  function automatic int unsigned next_gap(input bit enabled);
    if (!enabled || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 17);
  endfunction

  // Valid stays high from word to word; it drops at the start of a gap and when results are drained.
  task automatic send_byte(input logic [7:0] c, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= c;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    account_byte(c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], next_gap(idle_sender));
  endtask

  // Lets the last result out and the engine settle before the pattern moves.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input lwm_pkg::cfg_reg_e idx,
                           input logic [lwm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == lwm_pkg::REG_PATTERN_LENGTH) shadow_plen = val[lwm_pkg::PLEN_W-1:0];
    else shadow_words[int'(idx) - int'(lwm_pkg::REG_PATTERN_WORD_0)] = val;
  endtask

  task automatic load_pattern(input int unsigned len,
                              input logic [lwm_pkg::CFG_BYTES*8-1:0] text);
    drain_results();
    write_reg(lwm_pkg::REG_PATTERN_LENGTH, lwm_pkg::CFG_DATA_W'(len));
    for (int w = 0; w < int'(lwm_pkg::WORD_COUNT); w++) begin
      write_reg(lwm_pkg::cfg_reg_e'(int'(lwm_pkg::REG_PATTERN_WORD_0) + w),
                text[w*lwm_pkg::CFG_DATA_W +: lwm_pkg::CFG_DATA_W]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [lwm_pkg::CFG_BYTES*8-1:0] pack_pattern(input string s);
    logic [lwm_pkg::CFG_BYTES*8-1:0] r;
    r = '0;
    for (int i = 0; i < s.len() && i < int'(lwm_pkg::CFG_BYTES); i++) r[i*8 +: 8] = s[i];
    return r;
  endfunction

  function automatic logic [7:0] any_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == lwm_pkg::CH_CR || b == lwm_pkg::CH_LF);
    return b;
  endfunction

  function automatic logic [7:0] text_char();
    if ($urandom_range(0, 7) == 0) return any_text_byte();
    return $urandom_range(0, 1) ? "a" : "b";
  endfunction

  // Most lines are spelled out from the pattern so that matches are common;
  // some get one byte changed, the rest are free text.
  task automatic send_random_line();
    logic [7:0] body[$];
    logic [7:0] p;
    int         n;
    n = used_length();
    if ($urandom_range(0, 2) != 0) begin
      for (int i = 0; i < n; i++) begin
        p = pattern_char(i);
        if (p == lwm_pkg::CH_STAR) repeat ($urandom_range(0, 3)) body.push_back(text_char());
        else if (p == lwm_pkg::CH_QUEST) body.push_back(any_text_byte());
        else body.push_back(p);
      end
      if (body.size() != 0 && $urandom_range(0, 3) == 0)
        body[$urandom_range(0, body.size() - 1)] = text_char();
    end else begin
      repeat ($urandom_range(1, 12)) body.push_back(text_char());
    end
    if (body.size() == 0) body.push_back(text_char());
    foreach (body[i]) send_byte(body[i], next_gap(idle_sender));
    repeat ($urandom_range(1, 3))
      send_byte($urandom_range(0, 1) ? lwm_pkg::CH_CR : lwm_pkg::CH_LF,
                next_gap(idle_sender));
  endtask

  task automatic load_random_pattern();
    logic [lwm_pkg::CFG_BYTES*8-1:0] text;
    int unsigned                     len;
    int unsigned                     sel;
    int unsigned                     k;
    for (int i = 0; i < int'(lwm_pkg::CFG_BYTES / 4); i++) text[i*32 +: 32] = $urandom();
    sel = $urandom_range(0, 9);
    case (sel)
      0:       len = 0;
      1:       len = lwm_pkg::PATTERN_MAX;
      2:       len = $urandom_range(lwm_pkg::PATTERN_MAX + 1, 2**lwm_pkg::PLEN_W - 1);
      3:       len = $urandom_range(9, lwm_pkg::PATTERN_MAX - 1);
      default: len = $urandom_range(1, 8);
    endcase
    for (int i = 0; i < int'(len) && i < int'(lwm_pkg::PATTERN_MAX); i++) begin
      k = $urandom_range(0, 8);
      case (k)
        0, 1:    text[i*8 +: 8] = lwm_pkg::CH_STAR;
        2, 3:    text[i*8 +: 8] = lwm_pkg::CH_QUEST;
        4, 5:    text[i*8 +: 8] = "a";
        6, 7:    text[i*8 +: 8] = "b";
        default: text[i*8 +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    load_pattern(len, text);
  endtask

  // ------------------------------------------------------------------ checker

  initial begin : result_checker
    line_verdict_t want;
    int unsigned   wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && !out_stall_i) begin
        if (pending_lines.size() == 0) begin
          $display("%0t: result word with none expected: matched %0d line %0d length %0d",
                   $time, matched_o, line_number_o, line_length_o);
          mismatches++;
        end else begin
          want = pending_lines.pop_front();
          if (matched_o !== want.matched) begin
            $display("%0t: matched expected %0d actual %0d", $time, want.matched, matched_o);
            mismatches++;
          end
          if (line_number_o !== want.line_number) begin
            $display("%0t: line_number expected %0d actual %0d",
                     $time, want.line_number, line_number_o);
            mismatches++;
          end
          if (line_length_o !== want.line_length) begin
            $display("%0t: line_length expected %0d actual %0d",
                     $time, want.line_length, line_length_o);
            mismatches++;
          end
        end
        wait_left = next_gap(idle_receiver);
      end
      if (hold_cycles != 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (wait_left != 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------------- tests

  // Reset pattern is a lone star: every non-empty line matches, runs of
  // terminators give nothing.
  task automatic test_reset_pattern();
    send_text("a\n\015\n\015");
    send_byte(8'h00, next_gap(idle_sender));
    send_byte(8'hFF, next_gap(idle_sender));
    send_byte(lwm_pkg::CH_LF, next_gap(idle_sender));
  endtask

  task automatic test_wildcards();
    load_pattern(4, pack_pattern("a?c*"));
    send_text("abc\nab\015");
  endtask

  task automatic test_empty_pattern();
    load_pattern(0, pack_pattern("*"));
    send_text("x\n");
  endtask

  // A length past the maximum saturates, so position 32 is the end.
  task automatic test_length_extremes();
    load_pattern(2**lwm_pkg::PLEN_W - 1, {lwm_pkg::CFG_BYTES{lwm_pkg::CH_STAR}});
    send_text("z\n");
    load_pattern(1, {lwm_pkg::CFG_BYTES{8'hFF}});
    send_byte(8'hFF, next_gap(idle_sender));
    send_byte(lwm_pkg::CH_LF, next_gap(idle_sender));
  endtask

  // NUL is an ordinary literal, and a CR literal can never be met.
  task automatic test_control_pattern_bytes();
    load_pattern(2, '0);
    send_byte(8'h00, next_gap(idle_sender));
    send_byte(8'h00, next_gap(idle_sender));
    send_byte(lwm_pkg::CH_CR, next_gap(idle_sender));
    load_pattern(1, pack_pattern("\015"));
    send_text("x\n");
  endtask

  // The position set survives a pattern change in the middle of a line.
  task automatic test_midline_change();
    load_pattern(2, pack_pattern("ab"));
    send_text("a");
    load_pattern(3, pack_pattern("?*c"));
    send_text("xyc\n");
  endtask

  task automatic test_long_line();
    idle_sender   = 1'b0;
    idle_receiver = 1'b0;
    load_pattern(2, pack_pattern("*q"));
    repeat (LONG_LINE) send_byte("q", 0);
    send_byte(lwm_pkg::CH_LF, 0);
  endtask

  // The receiver holds off while lines keep coming, so the block fills and
  // stalls its input; afterwards the sender waits for every result.
  task automatic test_output_hold_off();
    idle_sender   = 1'b0;
    idle_receiver = 1'b1;
    load_pattern(3, pack_pattern("a*b"));
    hold_cycles = 300;
    repeat (30) send_text("axb\n");
    drain_results();
  endtask

  task automatic test_random_stream();
    int unsigned goal;
    int unsigned phase_goal;
    int unsigned sel;
    goal = useful_bytes + RANDOM_ITEMS;
    while (useful_bytes < goal) begin
      load_random_pattern();
      sel           = $urandom_range(0, 3);
      idle_sender   = (sel != 0);
      idle_receiver = (sel != 1);
      phase_goal    = useful_bytes + $urandom_range(60, 200);
      while (useful_bytes < phase_goal && useful_bytes < goal) begin
        if ($urandom_range(0, 7) == 0)
          send_byte(8'($urandom_range(0, 255)), next_gap(idle_sender));
        else
          send_random_line();
      end
    end
  endtask

  initial begin : main_sequence
    live_pos      = close_over_stars(lwm_pkg::pos_set_t'(1));
    lines_seen    = '0;
    bytes_in_line = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pattern();
    test_wildcards();
    test_empty_pattern();
    test_length_extremes();
    test_control_pattern_bytes();
    test_midline_change();
    test_long_line();
    test_output_hold_off();
    test_random_stream();
    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
